[sv/utf8d_pkg.sv]
// utf8d_pkg: payload types and byte-class constants for the utf-8 decoder
// used by utf8_to_utf16_bmp_decoder; no dependencies
package utf8d_pkg;

	localparam logic [7:0] ASCII_MAX = 8'h7F;
	localparam logic [7:0] CONT_LO   = 8'h80;
	localparam logic [7:0] CONT_HI   = 8'hBF;
	localparam logic [7:0] LEAD2_LO  = 8'hC0;
	localparam logic [7:0] LEAD2_HI  = 8'hDF;
	localparam logic [7:0] LEAD3_LO  = 8'hE0;
	localparam logic [7:0] LEAD3_HI  = 8'hEF;

	localparam logic MODE_DATA  = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	// most units one input item can produce
	localparam int MAX_UNITS = 3;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        is_raw;
		logic        last;
	} out_item_t;

endpackage

[sv/utf8_to_utf16_bmp_decoder.sv]
// utf8_to_utf16_bmp_decoder: utf-8 byte stream to utf-16 code units (bmp only)
// depends on utf8d_pkg for payload types and byte-class constants
//
// channel  dir  handshake           payload
// in       in   in_valid/in_ready   utf8d_pkg::in_item_t  (mode, data_byte)
// out      out  out_valid/out_ready utf8d_pkg::out_item_t (code_unit, is_raw, last)
//
// an accepted item sits in the input stage, is decoded in one pass and loads the
// result group (up to three units), which drains one unit per cycle while out is
// ready; one item per cycle while each item yields at most one unit and out is
// not stalled; an item yielding several units holds the group until all drain;
// the first unit passes the input stage, then the result group, before it is valid
// arst_n clears the decode state and both stages; back-pressure on out stalls
// the input stage, which still takes one item while the result group waits
module utf8_to_utf16_bmp_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  utf8d_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output utf8d_pkg::out_item_t out_data
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_TWO,
		PH_THREE_A,
		PH_THREE_B
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] acc_q, acc_d;
	logic [7:0]  lead_q, lead_d;
	logic [7:0]  second_q, second_d;

	logic                v_s1;
	utf8d_pkg::in_item_t item_s1;

	logic [15:0] unit_q [utf8d_pkg::MAX_UNITS];
	logic        raw_q  [utf8d_pkg::MAX_UNITS];
	logic [1:0]  cnt_q;

	logic [15:0] unit_d [utf8d_pkg::MAX_UNITS];
	logic        raw_d  [utf8d_pkg::MAX_UNITS];
	logic [1:0]  cnt_d;

	logic group_free, advance, out_xfer, is_cont;
	logic [7:0] b;

	assign out_xfer   = out_valid && out_ready;
	assign group_free = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready);
	assign advance    = v_s1 && group_free;
	assign in_ready   = !v_s1 || group_free;

	assign out_valid          = (cnt_q != 2'd0);
	assign out_data.code_unit = unit_q[0];
	assign out_data.is_raw    = raw_q[0];
	assign out_data.last      = (cnt_q == 2'd1);

	assign b       = item_s1.data_byte;
	assign is_cont = (b >= utf8d_pkg::CONT_LO) && (b <= utf8d_pkg::CONT_HI);

	always_comb begin
		phase_d  = phase_q;
		acc_d    = acc_q;
		lead_d   = lead_q;
		second_d = second_q;
		cnt_d    = 2'd0;
		for (int i = 0; i < utf8d_pkg::MAX_UNITS; i++) begin
			unit_d[i] = 16'h0000;
			raw_d[i]  = 1'b1;
		end
		if (item_s1.mode == utf8d_pkg::MODE_FLUSH) begin
			// held bytes go out raw
			if (phase_q != PH_IDLE) begin
				unit_d[0] = {8'h00, lead_q};
				cnt_d     = 2'd1;
				if (phase_q == PH_THREE_B) begin
					unit_d[1] = {8'h00, second_q};
					cnt_d     = 2'd2;
				end
			end
			phase_d = PH_IDLE;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if ((b >= utf8d_pkg::LEAD2_LO) && (b <= utf8d_pkg::LEAD2_HI)) begin
						lead_d  = b;
						acc_d   = {5'b0, b[4:0], 6'b0};
						phase_d = PH_TWO;
					end else if ((b >= utf8d_pkg::LEAD3_LO) && (b <= utf8d_pkg::LEAD3_HI)) begin
						lead_d  = b;
						acc_d   = {b[3:0], 12'h000};
						phase_d = PH_THREE_A;
					end else begin
						unit_d[0] = {8'h00, b};
						raw_d[0]  = (b > utf8d_pkg::ASCII_MAX);
						cnt_d     = 2'd1;
					end
				end
				PH_TWO, PH_THREE_B: begin
					if (is_cont) begin
						acc_d     = acc_q | {10'b0, b[5:0]};
						unit_d[0] = acc_q | {10'b0, b[5:0]};
						raw_d[0]  = 1'b0;
						cnt_d     = 2'd1;
					end else if (phase_q == PH_TWO) begin
						unit_d[0] = {8'h00, lead_q};
						unit_d[1] = {8'h00, b};
						cnt_d     = 2'd2;
					end else begin
						unit_d[0] = {8'h00, lead_q};
						unit_d[1] = {8'h00, second_q};
						unit_d[2] = {8'h00, b};
						cnt_d     = 2'd3;
					end
					phase_d = PH_IDLE;
				end
				PH_THREE_A: begin
					second_d = b;
					if (is_cont) begin
						acc_d   = acc_q | {4'b0, b[5:0], 6'b0};
						phase_d = PH_THREE_B;
					end else begin
						unit_d[0] = {8'h00, lead_q};
						unit_d[1] = {8'h00, b};
						cnt_d     = 2'd2;
						phase_d   = PH_IDLE;
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			acc_q    <= 16'h0000;
			lead_q   <= 8'h00;
			second_q <= 8'h00;
			v_s1     <= 1'b0;
			item_s1  <= '0;
			cnt_q    <= 2'd0;
			for (int i = 0; i < utf8d_pkg::MAX_UNITS; i++) begin
				unit_q[i] <= 16'h0000;
				raw_q[i]  <= 1'b0;
			end
		end else begin
			if (in_valid && in_ready) begin
				v_s1    <= 1'b1;
				item_s1 <= in_data;
			end else if (advance) begin
				v_s1 <= 1'b0;
			end
			if (advance) begin
				phase_q  <= phase_d;
				acc_q    <= acc_d;
				lead_q   <= lead_d;
				second_q <= second_d;
				cnt_q    <= cnt_d;
				for (int i = 0; i < utf8d_pkg::MAX_UNITS; i++) begin
					unit_q[i] <= unit_d[i];
					raw_q[i]  <= raw_d[i];
				end
			end else if (out_xfer) begin
				// shift the group down by one unit
				cnt_q <= cnt_q - 2'd1;
				for (int i = 0; i < utf8d_pkg::MAX_UNITS - 1; i++) begin
					unit_q[i] <= unit_q[i + 1];
					raw_q[i]  <= raw_q[i + 1];
				end
			end
		end
	end

	// a flush with nothing held produces no unit
	a_idle_flush_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.mode == utf8d_pkg::MODE_FLUSH && phase_q == PH_IDLE)
		|=> !out_valid)
		else $error("flush while idle produced a unit");

	// after the last unit of a group is taken, nothing remains unless reloaded
	a_group_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && out_data.last && !advance) |=> !out_valid)
		else $error("result group did not drain after last unit");

	// a stalled group keeps its head unit
	a_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("head unit changed under back-pressure");

	// a lead byte while idle leaves a sequence pending and emits nothing
	a_lead_pends: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.mode == utf8d_pkg::MODE_DATA && phase_q == PH_IDLE
			&& item_s1.data_byte >= utf8d_pkg::LEAD2_LO
			&& item_s1.data_byte <= utf8d_pkg::LEAD3_HI)
		|=> (phase_q != PH_IDLE && !out_valid))
		else $error("lead byte did not start a sequence");

endmodule
